// ----- design/bso_pkg.sv -----
`timescale 1ns / 1ps

package bso_pkg;

   localparam int UNIVERSE_MAX_DEFAULT = 4095;
   localparam int WORD_BITS            = 64;
   localparam int BIT_W                = 6;
   localparam int VALUE_W              = 12;
   localparam int CMD_W                = 2;
   localparam int OP_W                 = 3;
   localparam int REQ_DATA_W           = 16;
   localparam int RSP_DATA_W           = 16;
   localparam int RSP_USER_W           = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_INS_A = 2'd1,
      CMD_INS_B = 2'd2,
      CMD_FETCH = 2'd3
   } cmd_type;

   typedef enum logic [OP_W-1:0] {
      OP_UNION     = 3'd0,
      OP_INTERSECT = 3'd1,
      OP_A_MINUS_B = 3'd2,
      OP_SYM_DIFF  = 3'd3,
      OP_NOT_A     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INSERT,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_item;
      logic dispatch;
      logic insert_step;
      logic scan_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type item_cmd;
      logic    cursor_zero;
      logic    scan_done;
      logic    out_free;
   } ctrl_status_type;

endpackage

// ----- design/bso_ctrl.sv -----
`timescale 1ns / 1ps

module bso_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  bso_pkg::ctrl_status_type status,
   output bso_pkg::ctrl_cmd_type    cmd
);
   import bso_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.item_cmd)
               CMD_CLEAR: state_in = ST_RESPOND;
               CMD_INS_A, CMD_INS_B: state_in = ST_INSERT;
               CMD_FETCH: state_in = status.cursor_zero ? ST_RESPOND : ST_SCAN;
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_INSERT: state_in = ST_RESPOND;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_DISPATCH: cmd.dispatch    = 1'b1;
         ST_INSERT:   cmd.insert_step = 1'b1;
         ST_SCAN:     cmd.scan_step   = 1'b1;
         ST_RESPOND:  cmd.load_out    = status.out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- design/bso_dpath.sv -----
`timescale 1ns / 1ps

module bso_dpath #(
   parameter int UNIVERSE_MAX = bso_pkg::UNIVERSE_MAX_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bso_pkg::CMD_W-1:0]    req_command,
   input  logic [bso_pkg::VALUE_W-1:0]  req_value,
   input  logic                         csr_write,
   input  logic [bso_pkg::OP_W-1:0]     csr_data,
   input  bso_pkg::ctrl_cmd_type        cmd,
   output bso_pkg::ctrl_status_type     status,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [bso_pkg::VALUE_W-1:0]  rsp_element,
   output logic                         rsp_found,
   output logic                         rsp_inserted
);
   import bso_pkg::*;

   localparam int ROWS_NEEDED = (UNIVERSE_MAX + WORD_BITS) / WORD_BITS;
   localparam int ROW_AW      = (ROWS_NEEDED > 1) ? $clog2(ROWS_NEEDED) : 1;
   localparam int MEM_ROWS    = 1 << ROW_AW;
   localparam int SCAN_W      = ROW_AW + BIT_W;
   localparam int LAST_BIT    = UNIVERSE_MAX % WORD_BITS;
   localparam logic [ROW_AW-1:0]    LAST_ROW  = ROW_AW'(UNIVERSE_MAX / WORD_BITS);
   localparam logic [SCAN_W-1:0]    LIMIT     = SCAN_W'(UNIVERSE_MAX);
   localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - 1 - LAST_BIT);

   logic [WORD_BITS-1:0] mem_a [MEM_ROWS];
   logic [WORD_BITS-1:0] mem_b [MEM_ROWS];

   logic [MEM_ROWS-1:0]  valid_a_ff, valid_a_in;
   logic [MEM_ROWS-1:0]  valid_b_ff, valid_b_in;
   logic [WORD_BITS-1:0] rd_a_ff, rd_b_ff;
   logic                 rd_va_ff, rd_vb_ff;

   cmd_type              item_cmd_ff;
   logic [VALUE_W-1:0]   item_value_ff;
   op_type               op_ff;
   logic [SCAN_W-1:0]    cursor_ff, cursor_in;
   logic [ROW_AW-1:0]    scan_row_ff, scan_row_in;
   logic [BIT_W-1:0]     scan_low_ff, scan_low_in;

   logic [VALUE_W-1:0]   res_elem_ff, res_elem_in;
   logic                 res_found_ff, res_found_in;
   logic                 res_ins_ff, res_ins_in;

   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_elem_ff;
   logic                 rsp_found_ff, rsp_ins_ff;

   logic [SCAN_W-1:0]    val_pos;
   logic [ROW_AW-1:0]    val_row;
   logic [BIT_W-1:0]     val_bit;
   logic                 in_range;
   logic [WORD_BITS-1:0] word_a, word_b, word_sel, set_word;
   logic                 present, ins_a, ins_b, wr_a, wr_b;
   logic                 rd_en;
   logic [ROW_AW-1:0]    rd_addr;
   logic [WORD_BITS-1:0] op_word, hit_word;
   logic                 any_hit;
   logic [BIT_W-1:0]     hit_idx;
   logic [SCAN_W-1:0]    hit_pos;

   assign val_pos  = SCAN_W'({{SCAN_W{1'b0}}, item_value_ff});
   assign val_row  = val_pos[SCAN_W-1:BIT_W];
   assign val_bit  = val_pos[BIT_W-1:0];
   assign in_range = (item_value_ff != '0) && (32'(item_value_ff) <= UNIVERSE_MAX);

   assign word_a   = rd_va_ff ? rd_a_ff : '0;
   assign word_b   = rd_vb_ff ? rd_b_ff : '0;
   assign word_sel = (item_cmd_ff == CMD_INS_B) ? word_b : word_a;
   assign present  = word_sel[val_bit];
   assign set_word = word_sel | (WORD_BITS'(1) << val_bit);
   assign ins_a    = cmd.insert_step && (item_cmd_ff == CMD_INS_A) && in_range && !present;
   assign ins_b    = cmd.insert_step && (item_cmd_ff == CMD_INS_B) && in_range && !present;
   assign wr_a     = ins_a;
   assign wr_b     = ins_b;

   assign rd_en = cmd.dispatch || cmd.scan_step;
   always_comb begin
      if (cmd.scan_step) begin
         rd_addr = scan_row_ff + ROW_AW'(1);
      end else if (item_cmd_ff == CMD_FETCH) begin
         rd_addr = cursor_ff[SCAN_W-1:BIT_W];
      end else begin
         rd_addr = val_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr];
         rd_b_ff <= mem_b[rd_addr];
      end
      if (wr_a) begin
         mem_a[val_row] <= set_word;
      end
      if (wr_b) begin
         mem_b[val_row] <= set_word;
      end
   end

   always_comb begin
      valid_a_in = valid_a_ff;
      valid_b_in = valid_b_ff;
      if (cmd.dispatch && (item_cmd_ff == CMD_CLEAR)) begin
         valid_a_in = '0;
         valid_b_in = '0;
      end
      if (wr_a) begin
         valid_a_in[val_row] = 1'b1;
      end
      if (wr_b) begin
         valid_b_in[val_row] = 1'b1;
      end
   end

   always_comb begin
      case (op_ff)
         OP_UNION:     op_word = word_a | word_b;
         OP_INTERSECT: op_word = word_a & word_b;
         OP_A_MINUS_B: op_word = word_a & ~word_b;
         OP_SYM_DIFF:  op_word = word_a ^ word_b;
         OP_NOT_A:     op_word = ~word_a;
         default:      op_word = '0;
      endcase
      hit_word = op_word & (ONES << scan_low_ff) &
                 ((scan_row_ff == LAST_ROW) ? LAST_MASK : ONES);
   end

   always_comb begin
      hit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hit_word[i]) begin
            hit_idx = BIT_W'(i);
         end
      end
   end

   assign any_hit = |hit_word;
   assign hit_pos = {scan_row_ff, hit_idx};

   always_comb begin
      cursor_in    = cursor_ff;
      scan_row_in  = scan_row_ff;
      scan_low_in  = scan_low_ff;
      res_elem_in  = res_elem_ff;
      res_found_in = res_found_ff;
      res_ins_in   = res_ins_ff;
      if (cmd.dispatch) begin
         res_elem_in  = '0;
         res_found_in = 1'b0;
         res_ins_in   = 1'b0;
         scan_row_in  = cursor_ff[SCAN_W-1:BIT_W];
         scan_low_in  = cursor_ff[BIT_W-1:0];
         if ((item_cmd_ff == CMD_CLEAR) ||
             ((item_cmd_ff == CMD_FETCH) && (cursor_ff == '0))) begin
            cursor_in = SCAN_W'(1);
         end
      end
      if (cmd.insert_step) begin
         res_ins_in = ins_a || ins_b;
      end
      if (cmd.scan_step) begin
         if (any_hit) begin
            res_elem_in  = VALUE_W'({{VALUE_W{1'b0}}, hit_pos});
            res_found_in = 1'b1;
            cursor_in    = (hit_pos == LIMIT) ? '0 : hit_pos + SCAN_W'(1);
         end else if (scan_row_ff == LAST_ROW) begin
            cursor_in = SCAN_W'(1);
         end else begin
            scan_row_in = scan_row_ff + ROW_AW'(1);
            scan_low_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= '0;
         valid_b_ff   <= '0;
         cursor_ff    <= SCAN_W'(1);
         op_ff        <= OP_UNION;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         cursor_ff  <= cursor_in;
         if (csr_write) begin
            op_ff <= op_type'(csr_data);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_va_ff <= valid_a_ff[rd_addr];
         rd_vb_ff <= valid_b_ff[rd_addr];
      end
      if (cmd.load_item) begin
         item_cmd_ff   <= cmd_type'(req_command);
         item_value_ff <= req_value;
      end
      scan_row_ff  <= scan_row_in;
      scan_low_ff  <= scan_low_in;
      res_elem_ff  <= res_elem_in;
      res_found_ff <= res_found_in;
      res_ins_ff   <= res_ins_in;
      if (cmd.load_out) begin
         rsp_elem_ff  <= res_elem_ff;
         rsp_found_ff <= res_found_ff;
         rsp_ins_ff   <= res_ins_ff;
      end
   end

   assign status.item_cmd    = item_cmd_ff;
   assign status.cursor_zero = (cursor_ff == '0);
   assign status.scan_done   = any_hit || (scan_row_ff == LAST_ROW);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_element  = rsp_elem_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_inserted = rsp_ins_ff;

endmodule

// ----- design/bitmap_set_operations.sv -----
`timescale 1ns / 1ps
// Two membership bitmaps, A and B, over the values 1..UNIVERSE_MAX, held in
// 64-bit rows of two memories with one valid bit per row.
// The req channel carries one transaction per command: tuser holds the
// command (clear, insert into A, insert into B, fetch next member) and tdata
// the value to insert. Every request yields exactly one rsp transaction.
// The csr channel writes the operation register that selects the result
// set of a fetch (union, intersection, A minus B, symmetric difference,
// complement of A); it is always ready and should be written while idle.
// After acceptance, a clear runs through the dispatch and respond states,
// an insert through dispatch, insert and respond, and a fetch through
// dispatch, the row scan (skipped at a zero cursor) and respond. The row
// scan, one memory row per cycle, sets the fetch time. A new request is
// taken in the cycle after the result moves into the output register.
// Reset empties both sets at once by clearing the row valid bits, sets the
// read cursor to 1 and the operation to union. A clear command does the same
// to the sets and cursor. When the receiver stalls, the result waits in the
// output register; one more request may be worked on, and it then holds
// until the output register is free.
module bitmap_set_operations #(
   parameter int UNIVERSE_MAX = bso_pkg::UNIVERSE_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bso_pkg::REQ_DATA_W-1:0]  req_tdata,  // value[11:0], zero pad
   input  logic [bso_pkg::CMD_W-1:0]       req_tuser,  // command[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bso_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // element[11:0], zero pad
   output logic [bso_pkg::RSP_USER_W-1:0]  rsp_tuser,  // found[0], inserted[1]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bso_pkg::OP_W-1:0]        csr_data    // operation[2:0]
);
   import bso_pkg::*;

   ctrl_cmd_type       cmd;
   ctrl_status_type    status;
   logic [VALUE_W-1:0] element;
   logic               found;
   logic               inserted;

   assign csr_ready = 1'b1;

   bso_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bso_dpath #(
      .UNIVERSE_MAX (UNIVERSE_MAX)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_tuser),
      .req_value    (req_tdata[VALUE_W-1:0]),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_element  (element),
      .rsp_found    (found),
      .rsp_inserted (inserted)
   );

   assign rsp_tdata = {{(RSP_DATA_W - VALUE_W){1'b0}}, element};
   assign rsp_tuser = {inserted, found};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_found_xor_inserted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("response flags both found and inserted");

   a_miss_has_no_element: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("element nonzero on a response without found");

   a_fetch_scans: assert property (@(posedge clock) disable iff (reset)
      (cmd.dispatch && (status.item_cmd == CMD_FETCH) && !status.cursor_zero)
      |=> cmd.scan_step)
      else $error("fetch with a live cursor did not start a row scan");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import bso_pkg::*;

   localparam logic [OP_W-1:0] OP_EMPTY_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_EMPTY_HI = 3'd7;
   localparam int TOP_VALUE = 4095;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 105;
   localparam int MAX_PRINTS = 50;

   typedef struct {
      logic [VALUE_W-1:0] element;
      logic               found;
      logic               inserted;
   } set_answer_type;

   class set_scoreboard;
      bit                 members_a [TOP_VALUE+1];
      bit                 members_b [TOP_VALUE+1];
      logic [VALUE_W-1:0] cursor;
      logic [OP_W-1:0]    operation;
      set_answer_type     answer_q [$];
      int                 errors;

      function new();
         empty_sets();
         operation = OP_UNION;
         errors = 0;
      endfunction

      function void empty_sets();
         foreach (members_a[i]) begin
            members_a[i] = 0;
            members_b[i] = 0;
         end
         cursor = 1;
      endfunction

      function void set_operation(logic [OP_W-1:0] op);
         operation = op;
      endfunction

      function bit in_result(int v);
         bit a;
         bit b;
         a = members_a[v];
         b = members_b[v];
         case (operation)
            OP_UNION:     return a | b;
            OP_INTERSECT: return a & b;
            OP_A_MINUS_B: return a & ~b;
            OP_SYM_DIFF:  return a ^ b;
            OP_NOT_A:     return ~a;
            default:      return 0;
         endcase
      endfunction

      function void note_request(cmd_type cmd, logic [VALUE_W-1:0] value);
         set_answer_type ans;
         int v;
         ans.element = 0;
         ans.found = 0;
         ans.inserted = 0;
         case (cmd)
            CMD_CLEAR: empty_sets();
            CMD_INS_A: begin
               if (value != 0 && !members_a[value]) begin
                  members_a[value] = 1;
                  ans.inserted = 1;
               end
            end
            CMD_INS_B: begin
               if (value != 0 && !members_b[value]) begin
                  members_b[value] = 1;
                  ans.inserted = 1;
               end
            end
            default: begin
               if (cursor != 0) begin
                  for (v = cursor; v <= TOP_VALUE; v++) begin
                     if (in_result(v)) begin
                        ans.element = VALUE_W'(v);
                        ans.found = 1;
                        break;
                     end
                  end
               end
               if (ans.found)
                  cursor = (ans.element == TOP_VALUE) ? '0 : ans.element + VALUE_W'(1);
               else
                  cursor = 1;
            end
         endcase
         answer_q.push_back(ans);
      endfunction

      function void check_response(logic [VALUE_W-1:0] element, logic found, logic inserted);
         set_answer_type ans;
         if (answer_q.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTS)
               $display("%0t: unexpected rsp transaction element=%0d found=%0b inserted=%0b",
                        $time, element, found, inserted);
            return;
         end
         ans = answer_q.pop_front();
         if (element !== ans.element || found !== ans.found || inserted !== ans.inserted) begin
            errors++;
            if (errors <= MAX_PRINTS)
               $display({"%0t: rsp mismatch expected element=%0d found=%0b inserted=%0b,",
                         " actual element=%0d found=%0b inserted=%0b"},
                        $time, ans.element, ans.found, ans.inserted,
                        element, found, inserted);
         end
      endfunction

      function int pending();
         return answer_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [OP_W-1:0]       csr_data;

   set_scoreboard sb = new();
   bit            hold_request = 0;
   int            burst_left = 0;

   bitmap_set_operations u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[VALUE_W-1:0], rsp_tuser[0], rsp_tuser[1]);
   end

   function automatic logic ready_for_mode(int mode);
      case (mode)
         0, 1:    return 1'b1;
         2:       return 1'b0;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   initial begin
      int seg;
      int mode;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            seg = $urandom_range(1, 16);
            mode = $urandom_range(0, 3);
            rsp_tready <= ready_for_mode(mode);
            repeat (seg - 1) begin
               @(posedge clock);
               rsp_tready <= ready_for_mode(mode);
            end
         end
      end
   end

   task automatic issue(cmd_type cmd, logic [VALUE_W-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-VALUE_W){1'b0}}, value};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, value);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_operation(logic [OP_W-1:0] op);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= op;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_operation(op);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 0;
      else if (r < 10)
         return VALUE_W'($urandom_range(1, 48));
      else if (r < 15)
         return VALUE_W'($urandom_range(TOP_VALUE - 47, TOP_VALUE));
      else
         return VALUE_W'($urandom_range(0, TOP_VALUE));
   endfunction

   initial begin
      logic [OP_W-1:0] phase_ops [7];
      int count;
      int runs;
      int r;
      phase_ops = '{OP_INTERSECT, OP_A_MINUS_B, OP_SYM_DIFF, OP_NOT_A,
                    OP_EMPTY_LO, OP_UNION, OP_EMPTY_HI};
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CLEAR;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = OP_UNION;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_operation(OP_UNION);
      issue(CMD_INS_A, 0);
      issue(CMD_INS_A, 1);
      issue(CMD_INS_A, 1);
      issue(CMD_INS_A, TOP_VALUE);
      issue(CMD_INS_B, TOP_VALUE);
      issue(CMD_INS_B, 2048);
      issue(CMD_INS_B, 0);
      issue(CMD_FETCH, TOP_VALUE);
      issue(CMD_INS_B, 1);
      issue(CMD_FETCH, 0);
      issue(CMD_FETCH, 0);
      issue(CMD_FETCH, 0);
      issue(CMD_FETCH, 0);
      issue(CMD_CLEAR, TOP_VALUE);
      issue(CMD_FETCH, 0);
      issue(CMD_INS_A, 2730);
      issue(CMD_INS_B, 1365);
      issue(CMD_FETCH, 0);
      issue(CMD_FETCH, 0);
      issue(CMD_FETCH, 0);
      issue(CMD_INS_B, 2730);
      issue(CMD_FETCH, 0);

      for (int p = 0; p < 7; p++) begin
         write_operation(phase_ops[p]);
         count = 0;
         while (count < PHASE_ITEMS) begin
            if (p == 2 && count >= 40 && count < 42)
               hold_request = 1;
            r = $urandom_range(0, 99);
            if (r < 3) begin
               issue(CMD_CLEAR, VALUE_W'($urandom_range(0, TOP_VALUE)));
               count++;
            end else if (r < 38) begin
               issue(CMD_INS_A, pick_value());
               count++;
            end else if (r < 70) begin
               issue(CMD_INS_B, pick_value());
               count++;
            end else begin
               runs = $urandom_range(1, 8);
               repeat (runs) issue(CMD_FETCH, VALUE_W'($urandom_range(0, TOP_VALUE)));
               count += runs;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bso_pkg.sv
design/bso_ctrl.sv
design/bso_dpath.sv
design/bitmap_set_operations.sv
verif/tb_top.sv
